// ===== rtl/rce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, constants and the month table of the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int unsigned EPOCH_YEAR      = 1970;
  // leap years in 1..1969
  localparam int unsigned LEAPS_BEFORE    = 477;
  localparam int unsigned SEC_PER_DAY     = 86400;
  localparam int unsigned SEC_PER_HOUR    = 3600;
  localparam int unsigned SEC_PER_MIN     = 60;
  localparam logic [38:0] SEC_MAX         = 39'h3F_FFFF_FFFF;

  typedef logic [6:0] sec_t;
  typedef logic [6:0] min_t;
  typedef logic [5:0] hour_t;
  typedef logic [5:0] day_t;
  typedef logic [3:0] month_t;
  typedef logic [6:0] yic_t;
  typedef logic [6:0] cent_t;

  // after decode: full year, (year-1) split as q*100+r, day of year, time of day
  typedef struct packed {
    logic               ok;
    logic [13:0]        year;
    logic [7:0]         q;
    logic [6:0]         r;
    logic signed [9:0]  yday;
    logic [17:0]        tod;
  } s1_t;

  typedef struct packed {
    logic               ok;
    logic [22:0]        whole;
    logic signed [9:0]  yday;
    logic [17:0]        tod;
  } s2_t;

  typedef struct packed {
    logic               ok;
    logic signed [23:0] days;
    logic [17:0]        tod;
  } s3_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/rce_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_front
// First stage: range checks, full year, leap rule, day of year and time of
// day in seconds.
// ----------------------------------------------------------------------------
module rce_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rce_pkg::sec_t   rtc_seconds,
  input  rce_pkg::min_t   rtc_minutes,
  input  rce_pkg::hour_t  rtc_hours,
  input  rce_pkg::day_t   rtc_day,
  input  rce_pkg::month_t rtc_month,
  input  rce_pkg::yic_t   rtc_year_in_century,
  input  rce_pkg::cent_t  rtc_century,
  output logic           s1_valid,
  output rce_pkg::s1_t    s1
);
  import rce_pkg::*;

  s1_t        s1_next;
  logic       leap;
  logic       yic_ge100;
  logic [1:0] cent_low;
  logic [8:0] yday_u;

  always_comb begin
    s1_next.ok = (rtc_month >= 4'd1) && (rtc_month <= 4'd12) && (rtc_day <= 6'd31) &&
                 (rtc_minutes <= 7'd60) && (rtc_seconds <= 7'd60) && (rtc_hours <= 6'd24);
    s1_next.year = 14'({7'b0, rtc_century} * 14'd100) + {7'b0, rtc_year_in_century};

    // year-1 = q*100 + r, taken apart without a divider
    if (rtc_year_in_century == 7'd0) begin
      s1_next.q = {1'b0, rtc_century} - 8'd1;
      s1_next.r = 7'd99;
    end else if (rtc_year_in_century >= 7'd101) begin
      s1_next.q = {1'b0, rtc_century} + 8'd1;
      s1_next.r = rtc_year_in_century - 7'd101;
    end else begin
      s1_next.q = {1'b0, rtc_century};
      s1_next.r = rtc_year_in_century - 7'd1;
    end

    // year mod 4 follows the year in century, year/100 is century plus carry
    yic_ge100 = rtc_year_in_century >= 7'd100;
    cent_low  = rtc_century[1:0] + {1'b0, yic_ge100};
    leap = (rtc_year_in_century[1:0] == 2'd0) &&
           (!((rtc_year_in_century == 7'd0) || (rtc_year_in_century == 7'd100)) ||
            (cent_low == 2'd0));

    yday_u = days_before_month(rtc_month) +
             {8'b0, leap && (rtc_month > 4'd2)} + {3'b0, rtc_day};
    s1_next.yday = $signed({1'b0, yday_u}) - 10'sd1;

    s1_next.tod = 18'({6'b0, rtc_hours} * 18'(SEC_PER_HOUR)) +
                  18'({11'b0, rtc_minutes} * 18'(SEC_PER_MIN)) +
                  {11'b0, rtc_seconds};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1 <= s1_next;
  end

endmodule

// ===== rtl/rce_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_days
// Two stages: days of whole years since the epoch, then the signed day
// count including the day of year.
// ----------------------------------------------------------------------------
module rce_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        s1_valid,
  input  rce_pkg::s1_t s1,
  output logic        s3_valid,
  output rce_pkg::s3_t s3
);
  import rce_pkg::*;

  logic        s2_valid;
  s2_t         s2;
  s2_t         s2_next;
  s3_t         s3_next;
  logic [22:0] yspan;

  always_comb begin
    yspan = 23'(s1.year) - 23'(EPOCH_YEAR);
    s2_next.ok   = s1.ok;
    s2_next.yday = s1.yday;
    s2_next.tod  = s1.tod;
    // 365 per year plus leaps(year-1) - leaps(1969); leaps(n) = 24q + r/4 + q/4
    if (s1.year > 14'(EPOCH_YEAR)) begin
      s2_next.whole = 23'(yspan * 23'd365) + 23'({15'b0, s1.q} * 23'd24) +
                      {18'b0, s1.r[6:2]} + {17'b0, s1.q[7:2]} - 23'(LEAPS_BEFORE);
    end else begin
      s2_next.whole = 23'd0;
    end
  end

  always_comb begin
    s3_next.ok   = s2.ok;
    s3_next.tod  = s2.tod;
    s3_next.days = $signed({1'b0, s2.whole}) + {{14{s2.yday[9]}}, s2.yday};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s2 <= s2_next;
    s3 <= s3_next;
  end

endmodule

// ===== rtl/rce_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_scale
// Two stages: day count to seconds plus time of day, then saturation,
// invalid forcing and the result register.
// ----------------------------------------------------------------------------
module rce_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               s3_valid,
  input  rce_pkg::s3_t        s3,
  output logic               done,
  output logic signed [38:0] epoch_seconds,
  output logic               fields_valid
);
  import rce_pkg::*;

  localparam logic signed [17:0] DAY_SECONDS = 18'(SEC_PER_DAY);

  logic               s4_valid;
  logic               s4_ok;
  logic signed [41:0] s4_total;
  logic signed [41:0] days_wide;
  logic signed [41:0] total_next;
  logic signed [38:0] epoch_next;

  always_comb begin
    // widen before the product so the full day count in seconds is kept
    days_wide  = 42'(s3.days);
    total_next = days_wide * 42'(DAY_SECONDS) + $signed({24'b0, s3.tod});
  end

  always_comb begin
    priority if (!s4_ok) begin
      epoch_next = '0;
    end else if (s4_total > $signed({3'b0, SEC_MAX})) begin
      epoch_next = $signed(SEC_MAX);
    end else begin
      epoch_next = s4_total[38:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
    s4_ok         <= s3.ok;
    s4_total      <= total_next;
    epoch_seconds <= epoch_next;
    fields_valid  <= s4_ok;
  end

endmodule

// ===== rtl/rtc_calendar_to_epoch_seconds_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_to_epoch_seconds_unit
// Converts a binary RTC calendar snapshot to Unix epoch seconds with a
// range-check flag.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       rtc_seconds .. rtc_century
//  result    done (one cycle)   epoch_seconds, fields_valid
//
// five register stages: decode, whole-year days, day count, scale to
// seconds, saturate and output.
// one request is taken every cycle; busy is always low.
// synchronous reset clears the stage valid bits only.
// the receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rtc_calendar_to_epoch_seconds_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rce_pkg::sec_t       rtc_seconds,
  input  rce_pkg::min_t       rtc_minutes,
  input  rce_pkg::hour_t      rtc_hours,
  input  rce_pkg::day_t       rtc_day,
  input  rce_pkg::month_t     rtc_month,
  input  rce_pkg::yic_t       rtc_year_in_century,
  input  rce_pkg::cent_t      rtc_century,
  output logic               done,
  output logic signed [38:0] epoch_seconds,
  output logic               fields_valid
);
  import rce_pkg::*;

  logic s1_valid;
  s1_t  s1;
  logic s3_valid;
  s3_t  s3;

  assign busy = 1'b0;

  rce_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (start && !busy),
    .rtc_seconds         (rtc_seconds),
    .rtc_minutes         (rtc_minutes),
    .rtc_hours           (rtc_hours),
    .rtc_day             (rtc_day),
    .rtc_month           (rtc_month),
    .rtc_year_in_century (rtc_year_in_century),
    .rtc_century         (rtc_century),
    .s1_valid            (s1_valid),
    .s1                  (s1)
  );

  rce_days u_days (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  rce_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .s3_valid      (s3_valid),
    .s3            (s3),
    .done          (done),
    .epoch_seconds (epoch_seconds),
    .fields_valid  (fields_valid)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the calendar to epoch seconds converter: a short table of corner
// snapshots, then random snapshots with random start gaps, every result
// compared against a typed value or a behavioral day/second count kept here.
// ----------------------------------------------------------------------------
module tb;

  import rce_pkg::*;

  localparam int     NUM_DIRECTED   = 25;
  localparam int     NUM_RANDOM     = 1000;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     DRAIN_CYCLES   = 10;
  localparam int     MAX_REPORTS    = 10;
  localparam longint EPOCH          = longint'(EPOCH_YEAR);
  localparam longint SEC_LIMIT      = longint'(SEC_MAX);
  localparam longint MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                           304, 334};

  typedef struct packed {
    sec_t   seconds;
    min_t   minutes;
    hour_t  hours;
    day_t   day;
    month_t month;
    yic_t   yic;
    cent_t  century;
  } snapshot_t;

  typedef struct packed {
    logic [38:0] secs;
    logic        ok;
  } epoch_t;

  typedef struct packed {
    snapshot_t snap;
    bit        typed;
    longint    secs;
    logic      ok;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  sec_t               rtc_seconds = '0;
  min_t               rtc_minutes = '0;
  hour_t              rtc_hours = '0;
  day_t               rtc_day = '0;
  month_t             rtc_month = '0;
  yic_t               rtc_year_in_century = '0;
  cent_t              rtc_century = '0;
  logic               done;
  logic signed [38:0] epoch_seconds;
  logic               fields_valid;

  epoch_t expected_epochs[$];
  int     failures = 0;
  int     idle_cycles = 0;
  row_t   directed_rows [NUM_DIRECTED];

  rtc_calendar_to_epoch_seconds_unit u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .rtc_seconds         (rtc_seconds),
    .rtc_minutes         (rtc_minutes),
    .rtc_hours           (rtc_hours),
    .rtc_day             (rtc_day),
    .rtc_month           (rtc_month),
    .rtc_year_in_century (rtc_year_in_century),
    .rtc_century         (rtc_century),
    .done                (done),
    .epoch_seconds       (epoch_seconds),
    .fields_valid        (fields_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // leap years in 1..n
  function automatic longint leap_count(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic epoch_t calendar_to_epoch(snapshot_t s);
    epoch_t r;
    longint yr;
    longint days;
    longint secs;
    r.secs = '0;
    r.ok   = 1'b0;
    if (s.month >= 1 && s.month <= 12 && s.day <= 31 && s.minutes <= 60 &&
        s.seconds <= 60 && s.hours <= 24) begin
      yr   = longint'(s.century) * 100 + longint'(s.yic);
      days = 0;
      // years before the epoch contribute no whole years
      if (yr > EPOCH)
        days = 365 * (yr - EPOCH) + leap_count(yr - 1) - leap_count(EPOCH - 1);
      days += MONTH_OFFSET[s.month - 1];
      if (s.month > 2 && yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0))
        days += 1;
      // day zero is the last day of the previous month
      days += longint'(s.day) - 1;
      secs = ((days * 24 + longint'(s.hours)) * 60 + longint'(s.minutes)) * 60 +
             longint'(s.seconds);
      if (secs > SEC_LIMIT)
        secs = SEC_LIMIT;
      r.secs = secs[38:0];
      r.ok   = 1'b1;
    end
    return r;
  endfunction

  task automatic send_request(input snapshot_t s, input bit typed, input longint secs,
                              input logic ok, input int gap);
    epoch_t e;
    rtc_seconds         <= s.seconds;
    rtc_minutes         <= s.minutes;
    rtc_hours           <= s.hours;
    rtc_day             <= s.day;
    rtc_month           <= s.month;
    rtc_year_in_century <= s.yic;
    rtc_century         <= s.century;
    start               <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) begin
      e.secs = secs[38:0];
      e.ok   = ok;
    end else begin
      e = calendar_to_epoch(s);
    end
    expected_epochs.push_back(e);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result check, the receiver never stalls
  always @(posedge clk) begin
    epoch_t e;
    if (!rst && done) begin
      if (expected_epochs.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("unexpected result: secs=%0d ok=%0b", epoch_seconds, fields_valid);
        failures++;
      end else begin
        e = expected_epochs.pop_front();
        if (epoch_seconds !== e.secs || fields_valid !== e.ok) begin
          if (failures < MAX_REPORTS)
            $display("mismatch: expected secs=%0d ok=%0b, got secs=%0d ok=%0b",
                     $signed(e.secs), e.ok, epoch_seconds, fields_valid);
          failures++;
        end
      end
    end
  end

  // no request or result accepted for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    snapshot_t   s;
    logic [63:0] noise;
    int          kind;
    int          gap;
    bit          burst;
    directed_rows = '{
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b1},
      '{'{7'd60, 7'd60,  6'd24, 6'd1,  4'd1,  7'd70,  7'd19}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd0,  4'd1,  7'd70,  7'd19}, 1'b1, -64'sd86400,    1'b1},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd0,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd13, 7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd15, 7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd32, 4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd63, 4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd61,  6'd0,  6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd127, 6'd0,  6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd61, 7'd0,   6'd0,  6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd127, 7'd0,  6'd0,  6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd25, 6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd63, 6'd1,  4'd1,  7'd70,  7'd19}, 1'b1, 64'sd0,         1'b0},
      '{'{7'd59, 7'd59,  6'd23, 6'd31, 4'd12, 7'd69,  7'd19}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd3,  7'd0,   7'd19}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd3,  7'd0,   7'd20}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd29, 4'd2,  7'd24,  7'd20}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd3,  7'd24,  7'd20}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd1,  7'd0,   7'd20}, 1'b1, 64'sd946684800, 1'b1},
      '{'{7'd7,  7'd14,  6'd3,  6'd19, 4'd1,  7'd38,  7'd20}, 1'b1, 64'sd2147483647, 1'b1},
      '{'{7'd60, 7'd60,  6'd24, 6'd31, 4'd12, 7'd99,  7'd99}, 1'b0, 64'sd0,         1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd3,  7'd0,   7'd0},  1'b0, 64'sd0,         1'b0},
      '{'{7'd127, 7'd127, 6'd63, 6'd63, 4'd15, 7'd127, 7'd127}, 1'b1, 64'sd0,      1'b0},
      '{'{7'd0,  7'd0,   6'd0,  6'd1,  4'd1,  7'd127, 7'd127}, 1'b1, SEC_LIMIT,     1'b1}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].snap, directed_rows[i].typed, directed_rows[i].secs,
                   directed_rows[i].ok, $urandom_range(0, 15));

    // drain the pipe completely once before the random part
    start <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);

    burst = 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0)
        burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);

      s.seconds = 7'($urandom_range(0, 60));
      s.minutes = 7'($urandom_range(0, 60));
      s.hours   = 6'($urandom_range(0, 24));
      s.day     = 6'($urandom_range(0, 31));
      s.month   = 4'($urandom_range(1, 12));
      s.yic     = 7'($urandom_range(0, 99));
      s.century = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 99)) :
                                                7'($urandom_range(19, 21));
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
        noise = {$urandom(), $urandom()};
        s = noise[43:0];
      end else if (kind >= 70) begin
        // one field pushed anywhere in its width
        case ($urandom_range(0, 6))
          0: s.seconds = 7'($urandom());
          1: s.minutes = 7'($urandom());
          2: s.hours   = 6'($urandom());
          3: s.day     = 6'($urandom());
          4: s.month   = 4'($urandom());
          5: s.yic     = 7'($urandom());
          default: s.century = 7'($urandom());
        endcase
      end

      send_request(s, 1'b0, 64'sd0, 1'b0, gap);
      if (i == NUM_RANDOM / 2) begin
        if (gap == 0)
          start <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && expected_epochs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
